@@ rtl/core/ccs_pkg.sv @@
package ccs_pkg;

  typedef enum logic [3:0] {
    ModeCode   = 4'd0,
    ModeSlash  = 4'd1,
    ModeLine   = 4'd2,
    ModeBlock  = 4'd3,
    ModeStar   = 4'd4,
    ModeStr    = 4'd5,
    ModeStrEsc = 4'd6,
    ModeChr    = 4'd7,
    ModeChrEsc = 4'd8
  } mode_e;

  localparam logic [7:0] CharApos   = 8'd39;
  localparam logic [7:0] CharQuote  = 8'd34;
  localparam logic [7:0] CharLf     = 8'd10;
  localparam logic [7:0] CharBslash = 8'd92;
  localparam logic [7:0] CharSlash  = 8'd47;
  localparam logic [7:0] CharStar   = 8'd42;
  localparam logic [7:0] CharSpace  = 8'd32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

endpackage

@@ rtl/core/ccs_front.sv @@
module ccs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_end_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ccs_pkg::entry_t   entry_o
);

  ccs_pkg::mode_e mode_q, mode_d;
  logic           accept;
  logic [1:0]     emit_cnt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d = mode_q;
    if (accept) begin
      if (in_end_i) begin
        mode_d = ccs_pkg::ModeCode;
      end else begin
        unique case (mode_q)
          ccs_pkg::ModeSlash: begin
            if (in_byte_i == ccs_pkg::CharSlash) begin
              mode_d = ccs_pkg::ModeLine;
            end else if (in_byte_i == ccs_pkg::CharStar) begin
              mode_d = ccs_pkg::ModeBlock;
            end else if (in_byte_i == ccs_pkg::CharQuote) begin
              mode_d = ccs_pkg::ModeStr;
            end else if (in_byte_i == ccs_pkg::CharApos) begin
              mode_d = ccs_pkg::ModeChr;
            end else begin
              mode_d = ccs_pkg::ModeCode;
            end
          end
          ccs_pkg::ModeLine: begin
            if (in_byte_i == ccs_pkg::CharLf) mode_d = ccs_pkg::ModeCode;
          end
          ccs_pkg::ModeBlock: begin
            if (in_byte_i == ccs_pkg::CharStar) mode_d = ccs_pkg::ModeStar;
          end
          ccs_pkg::ModeStar: begin
            if (in_byte_i == ccs_pkg::CharSlash) begin
              mode_d = ccs_pkg::ModeCode;
            end else if (in_byte_i != ccs_pkg::CharStar) begin
              mode_d = ccs_pkg::ModeBlock;
            end
          end
          ccs_pkg::ModeStr: begin
            if (in_byte_i == ccs_pkg::CharBslash) begin
              mode_d = ccs_pkg::ModeStrEsc;
            end else if (in_byte_i == ccs_pkg::CharQuote) begin
              mode_d = ccs_pkg::ModeCode;
            end
          end
          ccs_pkg::ModeStrEsc: mode_d = ccs_pkg::ModeStr;
          ccs_pkg::ModeChr: begin
            if (in_byte_i == ccs_pkg::CharBslash) begin
              mode_d = ccs_pkg::ModeChrEsc;
            end else if (in_byte_i == ccs_pkg::CharApos) begin
              mode_d = ccs_pkg::ModeCode;
            end
          end
          ccs_pkg::ModeChrEsc: mode_d = ccs_pkg::ModeChr;
          default: begin
            if (in_byte_i == ccs_pkg::CharSlash) begin
              mode_d = ccs_pkg::ModeSlash;
            end else if (in_byte_i == ccs_pkg::CharQuote) begin
              mode_d = ccs_pkg::ModeStr;
            end else if (in_byte_i == ccs_pkg::CharApos) begin
              mode_d = ccs_pkg::ModeChr;
            end else begin
              mode_d = ccs_pkg::ModeCode;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    emit_cnt       = 2'd0;
    entry_o.first  = in_byte_i;
    entry_o.second = in_byte_i;
    if (in_end_i) begin
      entry_o.first = ccs_pkg::CharSlash;
      if (mode_q == ccs_pkg::ModeSlash) emit_cnt = 2'd1;
    end else begin
      unique case (mode_q) inside
        ccs_pkg::ModeSlash: begin
          entry_o.first = ccs_pkg::CharSlash;
          if (in_byte_i != ccs_pkg::CharSlash && in_byte_i != ccs_pkg::CharStar) begin
            emit_cnt = 2'd2;
          end
        end
        ccs_pkg::ModeLine: begin
          if (in_byte_i == ccs_pkg::CharLf) emit_cnt = 2'd1;
        end
        ccs_pkg::ModeBlock: emit_cnt = 2'd0;
        ccs_pkg::ModeStar: begin
          entry_o.first = ccs_pkg::CharSpace;
          if (in_byte_i == ccs_pkg::CharSlash) emit_cnt = 2'd1;
        end
        ccs_pkg::ModeStr, ccs_pkg::ModeStrEsc,
        ccs_pkg::ModeChr, ccs_pkg::ModeChrEsc: emit_cnt = 2'd1;
        default: begin
          if (in_byte_i != ccs_pkg::CharSlash) emit_cnt = 2'd1;
        end
      endcase
    end
    entry_o.two = emit_cnt[1];
    push_o      = accept && (emit_cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccs_pkg::ModeCode;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

@@ rtl/core/ccs_queue.sv @@
module ccs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ccs_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ccs_pkg::entry_t head_o
);

  ccs_pkg::entry_t              mem_q [ccs_pkg::QDepth];
  logic [ccs_pkg::QAw-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ccs_pkg::QAw-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ccs_pkg::QAw:0]        cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (ccs_pkg::QAw+1)'(ccs_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/ccs_back.sv @@
module ccs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ccs_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       sec_valid_q;
  logic [7:0] sec_byte_q;
  logic       load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !sec_valid_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= !empty_i;
        sec_valid_q <= !empty_i && head_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        out_byte_q <= sec_byte_q;
        out_last_q <= 1'b1;
      end else begin
        out_byte_q <= head_i.first;
        out_last_q <= !head_i.two;
        sec_byte_q <= head_i.second;
      end
    end
  end

endmodule

@@ rtl/core/c_comment_stripper.sv @@
// C comment stripper: takes C source one byte per transaction and passes it
// on with comments removed. Line comments are dropped up to their newline, a
// block comment becomes one space, and quotes, backslash escapes and comment
// marks inside string and char literals pass untouched. A transaction with
// tlast set marks end of text: it flushes a pending slash and returns the
// scanner to code. Input runs at one byte per cycle unless the queue is full;
// each byte yields zero, one or two output bytes, the last of them flagged by
// tlast; the output side moves one byte per cycle while downstream is ready,
// so a lone slash before code yields two output bytes. A four-entry queue
// between scanner and output stage absorbs these bursts and downstream stalls.
module c_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  ccs_pkg::entry_t push_entry;
  ccs_pkg::entry_t head_entry;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ccs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_entry)
  );

  ccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
